// File: rtl/core/lbc_pkg.sv
// Package: shared constants, codes and types of the largest blob centroid block.
package lbc_pkg;

  localparam int unsigned MAX_WIDTH  = 512;
  localparam int unsigned MAX_HEIGHT = 256;
  localparam int unsigned XW         = $clog2(MAX_WIDTH);
  localparam int unsigned YW         = $clog2(MAX_HEIGHT);
  localparam int unsigned AW         = XW + YW;
  localparam int unsigned CAPACITY   = MAX_WIDTH * MAX_HEIGHT;

  // Field and register widths
  localparam int unsigned FW_W   = 10;
  localparam int unsigned FH_W   = 9;
  localparam int unsigned CNT_W  = 18;
  localparam int unsigned CX_W   = 9;
  localparam int unsigned CY_W   = 8;
  localparam int unsigned CLS_W  = 2;
  localparam int unsigned SUMX_W = CNT_W + XW;
  localparam int unsigned SUMY_W = CNT_W + YW;
  localparam int unsigned TOT_W  = FW_W + FH_W;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Map entry bits
  localparam int unsigned MAP_MASK = 0;
  localparam int unsigned MAP_VIS  = 1;

  // Size classes
  localparam logic [CLS_W-1:0] CLS_NONE   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SMALL  = 2'd1;
  localparam logic [CLS_W-1:0] CLS_MEDIUM = 2'd2;
  localparam logic [CLS_W-1:0] CLS_LARGE  = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_MIN    = 3'd2;
  localparam logic [2:0] REG_SMALL  = 3'd3;
  localparam logic [2:0] REG_LARGE  = 3'd4;

  typedef struct packed {
    logic [FW_W-1:0]  frame_width;
    logic [FH_W-1:0]  frame_height;
    logic [CNT_W-1:0] min_area;
    logic [CNT_W-1:0] small_limit;
    logic [CNT_W-1:0] large_limit;
  } cfg_t;

endpackage

// File: rtl/core/lbc_pix_if.sv
// Interface: mask pixel request channel.
interface lbc_pix_if;
  logic valid;
  logic ready;
  logic pixel_set;
  logic end_of_frame;

  modport source (output valid, output pixel_set, output end_of_frame, input ready);
  modport sink   (input valid, input pixel_set, input end_of_frame, output ready);
endinterface

// File: rtl/core/lbc_res_if.sv
// Interface: blob result request channel.
interface lbc_res_if import lbc_pkg::*;;
  logic             valid;
  logic             ready;
  logic             found;
  logic [CX_W-1:0]  center_x;
  logic [CY_W-1:0]  center_y;
  logic [CNT_W-1:0] blob_area;
  logic [CLS_W-1:0] size_class;

  modport source (output valid, output found, output center_x, output center_y,
                  output blob_area, output size_class, input ready);
  modport sink   (input valid, input found, input center_x, input center_y,
                  input blob_area, input size_class, output ready);
endinterface

// File: rtl/core/lbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbc_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/core/lbc_div.sv
// Restoring divider: one quotient bit per cycle.
module lbc_div import lbc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUMX_W-1:0] dividend_i,
  input  logic [CNT_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [SUMX_W-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(SUMX_W);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [SUMX_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [CNT_W:0]    shift;

  assign shift = {rem_q[CNT_W-1:0], quo_q[SUMX_W-1]};

  // Step one bit
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    if (busy_q) begin
      if (shift >= {1'b0, div_q}) begin
        rem_d = shift - {1'b0, div_q};
        quo_d = {quo_q[SUMX_W-2:0], 1'b1};
      end else begin
        rem_d = shift;
        quo_d = {quo_q[SUMX_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(SUMX_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      div_d  = divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: rtl/core/lbc_ctrl.sv
// Frame loader, flood-fill sequencer and result stage around the pixel map and stack RAMs.
module lbc_ctrl import lbc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  lbc_pix_if.sink    pix,
  lbc_res_if.source  res
);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_SEED_RD = 4'd1;
  localparam logic [3:0] S_SEED_CK = 4'd2;
  localparam logic [3:0] S_ADV     = 4'd3;
  localparam logic [3:0] S_POP     = 4'd4;
  localparam logic [3:0] S_PIX     = 4'd5;
  localparam logic [3:0] S_NB      = 4'd6;
  localparam logic [3:0] S_FIN     = 4'd7;
  localparam logic [3:0] S_DIVX    = 4'd8;
  localparam logic [3:0] S_DIVY    = 4'd9;
  localparam logic [3:0] S_OUT     = 4'd10;

  logic [3:0]        state_q, state_d;
  logic [FW_W-1:0]   lx_q, lx_d;
  logic [FH_W-1:0]   ly_q, ly_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              ok_q, ok_d;
  logic [XW-1:0]     sx_q, sx_d;
  logic [YW-1:0]     sy_q, sy_d;
  logic [XW-1:0]     cur_x_q, cur_x_d;
  logic [YW-1:0]     cur_y_q, cur_y_d;
  logic [CNT_W-1:0]  sp_q, sp_d;
  logic [2:0]        nb_q, nb_d;
  logic              nbv_q, nbv_d;
  logic [AW-1:0]     nba_q, nba_d;
  logic [CNT_W-1:0]  area_q, area_d;
  logic [SUMX_W-1:0] sumx_q, sumx_d;
  logic [SUMY_W-1:0] sumy_q, sumy_d;
  logic [CNT_W-1:0]  best_q, best_d;
  logic [SUMX_W-1:0] bsx_q, bsx_d;
  logic [SUMY_W-1:0] bsy_q, bsy_d;
  logic [XW-1:0]     cx_q, cx_d;
  logic [YW-1:0]     cy_q, cy_d;

  logic              ov_q, ov_d;
  logic              of_q, of_d;
  logic [CX_W-1:0]   ocx_q, ocx_d;
  logic [CY_W-1:0]   ocy_q, ocy_d;
  logic [CNT_W-1:0]  oar_q, oar_d;
  logic [CLS_W-1:0]  ocl_q, ocl_d;

  logic              map_we;
  logic [AW-1:0]     map_wa, map_ra;
  logic [1:0]        map_wd, map_rd;
  logic              stk_we;
  logic [AW-1:0]     stk_wa, stk_ra;
  logic [AW-1:0]     stk_wd, stk_rd;

  logic              div_start, div_done;
  logic [SUMX_W-1:0] div_dividend, div_q;

  logic              accept;
  logic [CNT_W-1:0]  cnt_n;
  logic [TOT_W-1:0]  total;
  logic              seed_last;
  logic              found;

  lbc_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_map (
    .clk_i, .we_i(map_we), .waddr_i(map_wa), .wdata_i(map_wd),
    .raddr_i(map_ra), .rdata_o(map_rd)
  );

  lbc_ram #(.WIDTH(AW), .DEPTH(CAPACITY)) u_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_wa), .wdata_i(stk_wd),
    .raddr_i(stk_ra), .rdata_o(stk_rd)
  );

  lbc_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dividend),
    .divisor_i(best_q), .done_o(div_done), .quotient_o(div_q)
  );

  assign pix.ready = (state_q == S_LOAD);
  assign accept    = pix.valid && pix.ready;
  assign cnt_n     = (cnt_q != CNT_MAX) ? cnt_q + 1'b1 : cnt_q;
  assign total     = TOT_W'(cfg_i.frame_width) * TOT_W'(cfg_i.frame_height);
  assign seed_last = ((FW_W'(sx_q) + 1'b1) == cfg_i.frame_width) &&
                     ((FH_W'(sy_q) + 1'b1) == cfg_i.frame_height);
  assign found     = ok_q && (best_q >= cfg_i.min_area);

  // Sequence load, seed scan, fill and result
  always_comb begin
    state_d = state_q;
    lx_d = lx_q; ly_d = ly_q; cnt_d = cnt_q; ok_d = ok_q;
    sx_d = sx_q; sy_d = sy_q;
    cur_x_d = cur_x_q; cur_y_d = cur_y_q;
    sp_d = sp_q; nb_d = nb_q; nbv_d = nbv_q; nba_d = nba_q;
    area_d = area_q; sumx_d = sumx_q; sumy_d = sumy_q;
    best_d = best_q; bsx_d = bsx_q; bsy_d = bsy_q;
    cx_d = cx_q; cy_d = cy_q;
    ov_d = ov_q; of_d = of_q; ocx_d = ocx_q; ocy_d = ocy_q; oar_d = oar_q; ocl_d = ocl_q;
    map_we = 1'b0; map_wa = '0; map_wd = '0; map_ra = '0;
    stk_we = 1'b0; stk_wa = '0; stk_wd = '0; stk_ra = '0;
    div_start = 1'b0; div_dividend = bsx_q;

    // Drop the held result once taken
    if (ov_q && res.ready) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      S_LOAD: begin
        if (accept) begin
          map_wa = {ly_q[YW-1:0], lx_q[XW-1:0]};
          map_wd = {1'b0, pix.pixel_set};
          map_we = (32'(lx_q) < MAX_WIDTH) && (32'(ly_q) < MAX_HEIGHT);
          cnt_d  = cnt_n;
          if ((lx_q + 1'b1) == cfg_i.frame_width) begin
            lx_d = '0;
            ly_d = ly_q + 1'b1;
          end else begin
            lx_d = lx_q + 1'b1;
          end
          if (pix.end_of_frame) begin
            lx_d = '0; ly_d = '0; cnt_d = '0;
            sx_d = '0; sy_d = '0;
            best_d = '0; bsx_d = '0; bsy_d = '0; cx_d = '0; cy_d = '0;
            ok_d = (cfg_i.frame_width != '0) && (cfg_i.frame_height != '0) &&
                   (32'(cfg_i.frame_width) <= MAX_WIDTH) &&
                   (32'(cfg_i.frame_height) <= MAX_HEIGHT) &&
                   ((TOT_W + 1)'(cnt_n) == (TOT_W + 1)'(total));
            state_d = ok_d ? S_SEED_RD : S_OUT;
          end
        end
      end
      S_SEED_RD: begin
        map_ra  = {sy_q, sx_q};
        state_d = S_SEED_CK;
      end
      S_SEED_CK: begin
        if (map_rd[MAP_MASK] && !map_rd[MAP_VIS]) begin
          map_we = 1'b1; map_wa = {sy_q, sx_q}; map_wd = 2'b11;
          stk_we = 1'b1; stk_wa = '0; stk_wd = {sy_q, sx_q};
          sp_d = CNT_W'(1);
          area_d = '0; sumx_d = '0; sumy_d = '0;
          state_d = S_POP;
        end else begin
          state_d = S_ADV;
        end
      end
      S_ADV: begin
        if (seed_last) begin
          state_d = S_FIN;
        end else begin
          if ((FW_W'(sx_q) + 1'b1) == cfg_i.frame_width) begin
            sx_d = '0;
            sy_d = sy_q + 1'b1;
          end else begin
            sx_d = sx_q + 1'b1;
          end
          state_d = S_SEED_RD;
        end
      end
      S_POP: begin
        if (sp_q == '0) begin
          // Keep the earliest region on equal areas
          if (area_q > best_q) begin
            best_d = area_q; bsx_d = sumx_q; bsy_d = sumy_q;
          end
          state_d = S_ADV;
        end else begin
          stk_ra  = AW'(sp_q - 1'b1);
          sp_d    = sp_q - 1'b1;
          state_d = S_PIX;
        end
      end
      S_PIX: begin
        cur_x_d = stk_rd[XW-1:0];
        cur_y_d = stk_rd[AW-1:XW];
        area_d  = area_q + 1'b1;
        sumx_d  = sumx_q + SUMX_W'(stk_rd[XW-1:0]);
        sumy_d  = sumy_q + SUMY_W'(stk_rd[AW-1:XW]);
        nb_d    = '0;
        state_d = S_NB;
      end
      S_NB: begin
        // Issue the read of the next neighbor
        case (nb_q)
          3'd0: begin
            nbv_d = (cur_x_q != '0);
            nba_d = {cur_y_q, cur_x_q - 1'b1};
          end
          3'd1: begin
            nbv_d = ((FW_W'(cur_x_q) + 1'b1) < cfg_i.frame_width);
            nba_d = {cur_y_q, cur_x_q + 1'b1};
          end
          3'd2: begin
            nbv_d = (cur_y_q != '0);
            nba_d = {cur_y_q - 1'b1, cur_x_q};
          end
          3'd3: begin
            nbv_d = ((FH_W'(cur_y_q) + 1'b1) < cfg_i.frame_height);
            nba_d = {cur_y_q + 1'b1, cur_x_q};
          end
          default: begin
            nbv_d = 1'b0;
            nba_d = nba_q;
          end
        endcase
        map_ra = nba_d;
        // Check the neighbor read in the last cycle
        if (nb_q != '0 && nbv_q && map_rd[MAP_MASK] && !map_rd[MAP_VIS]) begin
          map_we = 1'b1; map_wa = nba_q; map_wd = 2'b11;
          stk_we = 1'b1; stk_wa = sp_q[AW-1:0]; stk_wd = nba_q;
          sp_d   = sp_q + 1'b1;
        end
        nb_d = nb_q + 1'b1;
        if (nb_q == 3'd4) begin
          state_d = S_POP;
        end
      end
      S_FIN: begin
        if (best_q == '0) begin
          state_d = S_OUT;
        end else begin
          div_start    = 1'b1;
          div_dividend = bsx_q;
          state_d      = S_DIVX;
        end
      end
      S_DIVX: begin
        if (div_done) begin
          cx_d         = div_q[XW-1:0];
          div_start    = 1'b1;
          div_dividend = SUMX_W'(bsy_q);
          state_d      = S_DIVY;
        end
      end
      S_DIVY: begin
        if (div_done) begin
          cy_d    = div_q[YW-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!ov_q) begin
          ov_d  = 1'b1;
          of_d  = found;
          ocx_d = found ? CX_W'(cx_q) : '0;
          ocy_d = found ? CY_W'(cy_q) : '0;
          oar_d = found ? best_q : '0;
          if (!found) begin
            ocl_d = CLS_NONE;
          end else if (best_q < cfg_i.small_limit) begin
            ocl_d = CLS_SMALL;
          end else if (best_q < cfg_i.large_limit) begin
            ocl_d = CLS_MEDIUM;
          end else begin
            ocl_d = CLS_LARGE;
          end
          state_d = S_LOAD;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      lx_q <= '0; ly_q <= '0; cnt_q <= '0; ok_q <= 1'b0;
      sx_q <= '0; sy_q <= '0; sp_q <= '0; nb_q <= '0; nbv_q <= 1'b0;
      area_q <= '0; sumx_q <= '0; sumy_q <= '0;
      best_q <= '0; bsx_q <= '0; bsy_q <= '0; cx_q <= '0; cy_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lx_q <= lx_d; ly_q <= ly_d; cnt_q <= cnt_d; ok_q <= ok_d;
      sx_q <= sx_d; sy_q <= sy_d; sp_q <= sp_d; nb_q <= nb_d; nbv_q <= nbv_d;
      area_q <= area_d; sumx_q <= sumx_d; sumy_q <= sumy_d;
      best_q <= best_d; bsx_q <= bsx_d; bsy_q <= bsy_d; cx_q <= cx_d; cy_q <= cy_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d; cur_y_q <= cur_y_d; nba_q <= nba_d;
    of_q <= of_d; ocx_q <= ocx_d; ocy_q <= ocy_d; oar_q <= oar_d; ocl_q <= ocl_d;
  end

  assign res.valid      = ov_q;
  assign res.found      = of_q;
  assign res.center_x   = ocx_q;
  assign res.center_y   = ocy_q;
  assign res.blob_area  = oar_q;
  assign res.size_class = ocl_q;

  // A push never runs past the stack depth
  a_stack_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_we && state_q == S_NB |-> 32'(sp_q) < CAPACITY)
    else $error("stack push beyond depth");

  // The fill cursor stays inside the active frame
  a_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_NB |-> (FW_W'(cur_x_q) < cfg_i.frame_width) &&
                        (FH_W'(cur_y_q) < cfg_i.frame_height))
    else $error("fill cursor outside frame");

  // The divider starts only with a nonzero area
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> best_q != '0)
    else $error("divide by zero area");

endmodule

// File: rtl/core/largest_blob_centroid_top.sv
// Top level: configuration registers on an APB-style port and the blob analysis core.
//
// Mask pixels arrive on the pixel channel one per request in raster order; the request
// with end_of_frame set closes the frame. While a frame loads, one pixel is taken every
// cycle. After the last pixel the block stops taking pixels and analyses the frame held
// in the pixel map RAM: a seed scan reads every active position, each set pixel is popped
// from the stack RAM and its in-frame neighbors are read, set unvisited ones being marked
// in the map and pushed, and the winning centroid takes two divisions. A frame whose
// pixel count or geometry is wrong gives a not-found result. One result request follows
// each frame. It waits in an output register until the receiver takes it, and loading
// of the next frame goes on meanwhile; a second result waits for the first to leave.
// Visited marks are cleared as the mask is loaded, so no clearing pass is needed. Reset
// returns the registers to their defaults and empties the frame; map and stack contents
// are not cleared.
module largest_blob_centroid_top import lbc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  lbc_pix_if.sink     pix_i,
  lbc_res_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_q, cfg_d;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // Write the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_WIDTH:  cfg_d.frame_width  = pwdata[FW_W-1:0];
        REG_HEIGHT: cfg_d.frame_height = pwdata[FH_W-1:0];
        REG_MIN:    cfg_d.min_area     = pwdata[CNT_W-1:0];
        REG_SMALL:  cfg_d.small_limit  = pwdata[CNT_W-1:0];
        REG_LARGE:  cfg_d.large_limit  = pwdata[CNT_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= FW_W'(320);
      cfg_q.frame_height <= FH_W'(240);
      cfg_q.min_area     <= CNT_W'(100);
      cfg_q.small_limit  <= CNT_W'(500);
      cfg_q.large_limit  <= CNT_W'(5000);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = 32'(cfg_q.frame_width);
      REG_HEIGHT: prdata = 32'(cfg_q.frame_height);
      REG_MIN:    prdata = 32'(cfg_q.min_area);
      REG_SMALL:  prdata = 32'(cfg_q.small_limit);
      REG_LARGE:  prdata = 32'(cfg_q.large_limit);
      default:    prdata = '0;
    endcase
  end

  lbc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .cfg_i (cfg_q),
    .pix   (pix_i),
    .res   (res_o)
  );

endmodule

// File: tb/sv/largest_blob_centroid_top_tb.sv
// Testbench: largest blob centroid top, directed frames then random frames checked by a predictor.
`timescale 1ns / 1ps

module largest_blob_centroid_top_tb;
  import lbc_pkg::*;

  typedef struct packed {
    logic             found;
    logic [CX_W-1:0]  center_x;
    logic [CY_W-1:0]  center_y;
    logic [CNT_W-1:0] blob_area;
    logic [CLS_W-1:0] size_class;
  } blob_res_t;

  typedef struct {
    bit          wr_cfg;
    int unsigned w, h, mn, sm, lg;
    int unsigned npix;
    logic [31:0] pix_bits;
    bit          typed;
    blob_res_t   res;
  } frame_row_t;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned RAND_ITEMS  = 1650;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel, penable, pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  lbc_pix_if pix();
  lbc_res_if res();

  largest_blob_centroid_top i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix),
    .res_o  (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #5 clk_i = ~clk_i;

  // Predictor copy of the configuration
  cfg_t        cfg_q;
  bit          frame_mask[$];
  int unsigned frame_cnt;
  blob_res_t   blob_exp_q[$];
  bit          typed_pending;
  blob_res_t   typed_res;
  bit          quiet;
  bit          failed;
  int unsigned cycles;

  // Flood-fill the stored frame and pick the largest 4-connected region
  function automatic blob_res_t predict_blob();
    blob_res_t   r;
    int unsigned w, h, total, sp, area, best, bcx, bcy, p, px, py, q;
    longint unsigned sx, sy;
    bit          vis[];
    int unsigned stk[];
    int unsigned nb[4];
    int          nn;
    r = '0;
    w = cfg_q.frame_width;
    h = cfg_q.frame_height;
    if (w == 0 || h == 0 || w > MAX_WIDTH || h > MAX_HEIGHT) return r;
    total = w * h;
    if (frame_cnt != total) return r;
    vis = new[total];
    stk = new[total];
    best = 0; bcx = 0; bcy = 0;
    for (int unsigned s = 0; s < total; s++) begin
      if (!frame_mask[s] || vis[s]) continue;
      vis[s] = 1'b1;
      sp = 0; area = 0; sx = 0; sy = 0;
      stk[sp++] = s;
      while (sp > 0) begin
        p = stk[--sp];
        px = p % w;
        py = p / w;
        area++;
        sx += px;
        sy += py;
        nn = 0;
        if (px > 0) nb[nn++] = p - 1;
        if (px + 1 < w) nb[nn++] = p + 1;
        if (py > 0) nb[nn++] = p - w;
        if (py + 1 < h) nb[nn++] = p + w;
        for (int k = 0; k < nn; k++) begin
          q = nb[k];
          if (frame_mask[q] && !vis[q]) begin
            vis[q] = 1'b1;
            stk[sp++] = q;
          end
        end
      end
      // keep the earliest region on equal areas
      if (area > best) begin
        best = area;
        bcx = sx / area;
        bcy = sy / area;
      end
    end
    if (best >= cfg_q.min_area) begin
      r.found      = 1'b1;
      r.center_x   = bcx[CX_W-1:0];
      r.center_y   = bcy[CY_W-1:0];
      r.blob_area  = best[CNT_W-1:0];
      if (best < cfg_q.small_limit) r.size_class = CLS_SMALL;
      else if (best < cfg_q.large_limit) r.size_class = CLS_MEDIUM;
      else r.size_class = CLS_LARGE;
    end
    return r;
  endfunction

  // Cycle counter and timeout
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    res.ready <= quiet || ($urandom_range(99) >= 20);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    blob_res_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (blob_exp_q.size() == 0) begin
        $error("unexpected result request");
        failed = 1'b1;
      end else begin
        e = blob_exp_q.pop_front();
        if (res.found !== e.found) begin
          $error("found: expected %0d actual %0d", e.found, res.found);
          failed = 1'b1;
        end
        if (res.center_x !== e.center_x) begin
          $error("center_x: expected %0d actual %0d", e.center_x, res.center_x);
          failed = 1'b1;
        end
        if (res.center_y !== e.center_y) begin
          $error("center_y: expected %0d actual %0d", e.center_y, res.center_y);
          failed = 1'b1;
        end
        if (res.blob_area !== e.blob_area) begin
          $error("blob_area: expected %0d actual %0d", e.blob_area, res.blob_area);
          failed = 1'b1;
        end
        if (res.size_class !== e.size_class) begin
          $error("size_class: expected %0d actual %0d", e.size_class, res.size_class);
          failed = 1'b1;
        end
      end
    end
  end

  // Write one register with a setup and an access phase, then mirror it
  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_WIDTH:  cfg_q.frame_width  = val[FW_W-1:0];
      REG_HEIGHT: cfg_q.frame_height = val[FH_W-1:0];
      REG_MIN:    cfg_q.min_area     = val[CNT_W-1:0];
      REG_SMALL:  cfg_q.small_limit  = val[CNT_W-1:0];
      REG_LARGE:  cfg_q.large_limit  = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Drop the pixel request, hold until every result is back and the block is idle
  task automatic drain();
    pix.valid <= 1'b0;
    while (blob_exp_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Send one pixel request and track it in the predictor once accepted
  task automatic send_pixel(input bit ps, input bit eof);
    while (!quiet && $urandom_range(99) < 20) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid        <= 1'b1;
    pix.pixel_set    <= ps;
    pix.end_of_frame <= eof;
    @(posedge clk_i);
    while (!pix.ready) @(posedge clk_i);
    if (frame_cnt < CAPACITY) frame_mask.push_back(ps);
    if (frame_cnt < CNT_MAX) frame_cnt++;
    if (eof) begin
      if (typed_pending) blob_exp_q.push_back(typed_res);
      else blob_exp_q.push_back(predict_blob());
      typed_pending = 1'b0;
      frame_mask.delete();
      frame_cnt = 0;
    end
  endtask

  frame_row_t dir_tbl[$];

  function automatic frame_row_t row(bit wr, int unsigned w, int unsigned h, int unsigned mn,
                                     int unsigned sm, int unsigned lg, int unsigned n,
                                     logic [31:0] bits, bit typed, blob_res_t r);
    frame_row_t t;
    t.wr_cfg = wr; t.w = w; t.h = h; t.mn = mn; t.sm = sm; t.lg = lg;
    t.npix = n; t.pix_bits = bits; t.typed = typed; t.res = r;
    return t;
  endfunction

  initial begin
    int unsigned items, w, h, n, dens, sel;
    frame_row_t  t;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    pix.valid = 1'b0; pix.pixel_set = 1'b0; pix.end_of_frame = 1'b0;
    quiet = 1'b0; typed_pending = 1'b0; frame_cnt = 0;
    cfg_q = '{frame_width: 320, frame_height: 240, min_area: 100,
              small_limit: 500, large_limit: 5000};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames: defaults mismatch, 1x1 extremes, ties, bad geometry, limits swapped
    dir_tbl.push_back(row(0, 0, 0, 0, 0, 0, 3, 32'b101, 1, '0));
    dir_tbl.push_back(row(1, 1, 1, 0, 0, 0, 1, 32'b0, 1,
                          '{1'b1, 9'd0, 8'd0, 18'd0, CLS_LARGE}));
    dir_tbl.push_back(row(1, 1, 1, 1, 2, 5, 1, 32'b1, 1,
                          '{1'b1, 9'd0, 8'd0, 18'd1, CLS_SMALL}));
    dir_tbl.push_back(row(1, 3, 2, 1, 2, 3, 6, 32'b101101, 0, '0));
    dir_tbl.push_back(row(1, 3, 3, 131072, 0, 0, 9, 32'h1ff, 1, '0));
    dir_tbl.push_back(row(1, 0, 1, 0, 0, 0, 1, 32'b1, 1, '0));
    dir_tbl.push_back(row(1, 1023, 511, 0, 0, 0, 1, 32'b1, 1, '0));
    dir_tbl.push_back(row(1, 512, 256, 0, 0, 0, 2, 32'b11, 1, '0));
    dir_tbl.push_back(row(1, 2, 2, 0, 10, 2, 4, 32'hf, 0, '0));
    dir_tbl.push_back(row(1, 4, 1, 262143, 262143, 262143, 4, 32'b1011, 1, '0));
    foreach (dir_tbl[i]) begin
      t = dir_tbl[i];
      drain();
      if (t.wr_cfg) begin
        write_reg(REG_WIDTH, t.w);
        write_reg(REG_HEIGHT, t.h);
        write_reg(REG_MIN, t.mn);
        write_reg(REG_SMALL, t.sm);
        write_reg(REG_LARGE, t.lg);
      end
      typed_pending = t.typed;
      typed_res     = t.res;
      for (int unsigned k = 0; k < t.npix; k++) send_pixel(t.pix_bits[k], k == t.npix - 1);
    end

    // Random frames, mostly well-formed, some with a wrong pixel count or bad geometry
    items = 0;
    while (items < RAND_ITEMS) begin
      quiet = (items > 600 && items < 900);
      if ($urandom_range(99) < 35) begin
        drain();
        sel = $urandom_range(9);
        if (sel == 0) write_reg(REG_WIDTH, $urandom_range(1023));
        else write_reg(REG_WIDTH, ($urandom_range(9) < 7) ? $urandom_range(1, 8)
                                                         : $urandom_range(1, 24));
        if (sel == 1) write_reg(REG_HEIGHT, $urandom_range(511));
        else write_reg(REG_HEIGHT, $urandom_range(1, ($urandom_range(1) ? 8 : 16)));
        case ($urandom_range(4))
          0: write_reg(REG_MIN, 0);
          1: write_reg(REG_MIN, $urandom_range(262143));
          default: write_reg(REG_MIN, $urandom_range(1, 12));
        endcase
        write_reg(REG_SMALL, $urandom_range(9) == 0 ? $urandom_range(262143)
                                                    : $urandom_range(0, 40));
        write_reg(REG_LARGE, $urandom_range(9) == 0 ? $urandom_range(262143)
                                                    : $urandom_range(0, 80));
      end
      w = cfg_q.frame_width;
      h = cfg_q.frame_height;
      n = w * h;
      if (n == 0 || n > 400 || $urandom_range(9) == 0) n = $urandom_range(1, 30);
      else if ($urandom_range(19) == 0) n = n + $urandom_range(1, 2);
      else if ($urandom_range(19) == 0 && n > 1) n = n - 1;
      dens = $urandom_range(100);
      for (int unsigned k = 0; k < n; k++) begin
        send_pixel($urandom_range(99) < dens, k == n - 1);
      end
      items += n;
    end
    quiet = 1'b0;

    drain();
    repeat (100) @(posedge clk_i);
    if (!failed) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
